FILE: rtl/ffsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsf_pkg: shared types and constants for the footer size finder
// Widths, end marker patterns, default sizes and register indexes.
// ----------------------------------------------------------------------------
package ffsf_pkg;

  // widths
  localparam int POSITION_BITS = 28;
  localparam int SIZE_BITS     = 28;
  localparam int LIMIT_BITS    = 28;
  localparam int CMP_BITS      = ((POSITION_BITS > SIZE_BITS) ? POSITION_BITS : SIZE_BITS) + 2;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
  localparam logic [SIZE_BITS-1:0]     SIZE_MAX = {SIZE_BITS{1'b1}};

  // default sizes when no end marker is seen
  localparam logic [SIZE_BITS-1:0] DEF_JPEG  = SIZE_BITS'(1024 * 1024);
  localparam logic [SIZE_BITS-1:0] DEF_PNG   = SIZE_BITS'(512 * 1024);
  localparam logic [SIZE_BITS-1:0] DEF_PDF   = SIZE_BITS'(2 * 1024 * 1024);
  localparam logic [SIZE_BITS-1:0] DEF_ZIP   = SIZE_BITS'(5 * 1024 * 1024);
  localparam logic [SIZE_BITS-1:0] DEF_OTHER = SIZE_BITS'(1024 * 1024);

  // register reset values
  localparam logic [LIMIT_BITS-1:0] RST_JPEG_LIMIT = LIMIT_BITS'(52428800);
  localparam logic [LIMIT_BITS-1:0] RST_PNG_LIMIT  = LIMIT_BITS'(20971520);
  localparam logic [LIMIT_BITS-1:0] RST_PDF_LIMIT  = LIMIT_BITS'(104857600);
  localparam logic [LIMIT_BITS-1:0] RST_ZIP_LIMIT  = LIMIT_BITS'(209715200);

  // marker patterns
  localparam logic [7:0]  JPEG_EOI_LEAD = 8'hFF;
  localparam logic [7:0]  JPEG_EOI_TAIL = 8'hD9;
  localparam logic [15:0] PNG_SIG_HEAD  = 16'h8950;
  localparam logic [31:0] PNG_IEND      = 32'h49454E44;  // "IEND"
  localparam logic [31:0] PDF_EOF_HEAD  = 32'h2525454F;  // "%%EO"
  localparam logic [7:0]  PDF_EOF_TAIL  = 8'h46;         // "F"
  localparam logic [31:0] ZIP_EOCD      = 32'h504B0506;

  // file type codes; codes above TYPE_OTHER act as other
  typedef enum logic [2:0] {
    TYPE_JPEG  = 3'd0,
    TYPE_PNG   = 3'd1,
    TYPE_PDF   = 3'd2,
    TYPE_ZIP   = 3'd3,
    TYPE_OTHER = 3'd4
  } ffsf_type_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_JPEG_LIMIT = 2'd0,
    REG_PNG_LIMIT  = 2'd1,
    REG_PDF_LIMIT  = 2'd2,
    REG_ZIP_LIMIT  = 2'd3
  } ffsf_reg_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] jpeg;
    logic [LIMIT_BITS-1:0] png;
    logic [LIMIT_BITS-1:0] pdf;
    logic [LIMIT_BITS-1:0] zip;
  } ffsf_limits_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] file_size;
    logic                 marker_found;
  } ffsf_result_t;

  // result handed from the search core to the result queue
  typedef struct packed {
    logic         push;
    ffsf_result_t result;
  } ffsf_core_out_t;

  function automatic logic [SIZE_BITS-1:0] type_default(input logic [2:0] t);
    logic [SIZE_BITS-1:0] d;
    case (t)
      TYPE_JPEG: d = DEF_JPEG;
      TYPE_PNG:  d = DEF_PNG;
      TYPE_PDF:  d = DEF_PDF;
      TYPE_ZIP:  d = DEF_ZIP;
      default:   d = DEF_OTHER;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/ffsf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsf_if: stream channels of the footer size finder
// Byte input channel and size result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic [2:0] file_type;
  logic       stream_end;

  modport source (output valid, data_byte, first_byte, file_type, stream_end, input ready);
  modport sink   (input valid, data_byte, first_byte, file_type, stream_end, output ready);
endinterface

interface ffsf_out_if import ffsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SIZE_BITS-1:0] file_size;
  logic                 marker_found;

  modport source (output valid, file_size, marker_found, input ready);
  modport sink   (input valid, file_size, marker_found, output ready);
endinterface

FILE: rtl/ffsf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsf_cfg_regs: search limit registers
// Four write-only limit registers loaded through the configuration port.
// ----------------------------------------------------------------------------
module ffsf_cfg_regs import ffsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [1:0]            cfg_index,
  input  logic [LIMIT_BITS-1:0] cfg_data,
  output ffsf_limits_t          limits
);

  ffsf_limits_t limits_q;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limits_q.jpeg <= RST_JPEG_LIMIT;
      limits_q.png  <= RST_PNG_LIMIT;
      limits_q.pdf  <= RST_PDF_LIMIT;
      limits_q.zip  <= RST_ZIP_LIMIT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_JPEG_LIMIT: limits_q.jpeg <= cfg_data;
        REG_PNG_LIMIT:  limits_q.png  <= cfg_data;
        REG_PDF_LIMIT:  limits_q.pdf  <= cfg_data;
        REG_ZIP_LIMIT:  limits_q.zip  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limits = limits_q;

endmodule

FILE: rtl/ffsf_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsf_search_core: per-byte footer match
// Holds byte position, four-byte window and search state; matches each
// accepted byte against the end marker of the active type combinationally.
// ----------------------------------------------------------------------------
module ffsf_search_core import ffsf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic [7:0]     data_byte,
  input  logic           first_byte,
  input  logic [2:0]     file_type,
  input  logic           stream_end,
  input  ffsf_limits_t   limits,
  output ffsf_core_out_t core_out
);

  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [31:0]              recent_bytes, recent_bytes_next;
  logic [2:0]               active_type, active_type_next;
  logic                     search_done, search_done_next;
  logic                     awaiting_comment_length, awaiting_comment_length_next;
  logic [POSITION_BITS-1:0] marker_position, marker_position_next;
  logic [7:0]               comment_length_low, comment_length_low_next;

  // view of the state with a restart folded in
  logic [POSITION_BITS-1:0] cur_pos;
  logic [31:0]              cur_recent;
  logic [2:0]               cur_type;
  logic                     cur_done;
  logic                     cur_await;
  logic [POSITION_BITS-1:0] cur_mpos;
  logic [7:0]               cur_clow;

  logic [31:0]         window;
  logic [CMP_BITS-1:0] p_ext, mpos_ext, size_ext;
  logic [CMP_BITS-1:0] jl_ext, pl_ext, dl_ext, zl_ext;
  logic                have, found, active;
  logic                await_n;
  logic [POSITION_BITS-1:0] mpos_n;
  logic [7:0]          clow_n;
  logic [SIZE_BITS-1:0] size_out;

  // restart on first byte
  always_comb begin
    if (first_byte) begin
      cur_pos    = '0;
      cur_recent = '0;
      cur_type   = file_type;
      cur_done   = 1'b0;
      cur_await  = 1'b0;
      cur_mpos   = '0;
      cur_clow   = '0;
    end else begin
      cur_pos    = byte_position;
      cur_recent = recent_bytes;
      cur_type   = active_type;
      cur_done   = search_done;
      cur_await  = awaiting_comment_length;
      cur_mpos   = marker_position;
      cur_clow   = comment_length_low;
    end
  end

  assign window   = {cur_recent[23:0], data_byte};
  assign p_ext    = CMP_BITS'(cur_pos);
  assign mpos_ext = CMP_BITS'(cur_mpos);
  assign jl_ext   = CMP_BITS'(limits.jpeg);
  assign pl_ext   = CMP_BITS'(limits.png);
  assign dl_ext   = CMP_BITS'(limits.pdf);
  assign zl_ext   = CMP_BITS'(limits.zip);

  // marker match and limit check for the active type
  always_comb begin
    have     = 1'b0;
    found    = 1'b0;
    size_ext = '0;
    await_n  = cur_await;
    mpos_n   = cur_mpos;
    clow_n   = cur_clow;
    case (cur_type)
      TYPE_JPEG: begin
        if (p_ext >= CMP_BITS'(3) && cur_recent[7:0] == JPEG_EOI_LEAD &&
            data_byte == JPEG_EOI_TAIL && (p_ext - CMP_BITS'(1)) < jl_ext) begin
          have     = 1'b1;
          found    = 1'b1;
          size_ext = p_ext + CMP_BITS'(1);
        end else if (p_ext + CMP_BITS'(1) >= jl_ext + CMP_BITS'(2)) begin
          have = 1'b1;
        end
      end
      TYPE_PNG: begin
        if (p_ext == CMP_BITS'(1) && window[15:0] != PNG_SIG_HEAD) begin
          have = 1'b1;
        end else if (p_ext >= CMP_BITS'(11) && window == PNG_IEND &&
                     (p_ext - CMP_BITS'(3)) < pl_ext) begin
          have     = 1'b1;
          found    = 1'b1;
          size_ext = p_ext + CMP_BITS'(5);
        end else if (p_ext + CMP_BITS'(1) >= pl_ext + CMP_BITS'(4)) begin
          have = 1'b1;
        end
      end
      TYPE_PDF: begin
        if (p_ext >= CMP_BITS'(9) && cur_recent == PDF_EOF_HEAD &&
            data_byte == PDF_EOF_TAIL && (p_ext - CMP_BITS'(4)) < dl_ext) begin
          have     = 1'b1;
          found    = 1'b1;
          size_ext = p_ext + CMP_BITS'(1);
        end else if (p_ext + CMP_BITS'(1) >= dl_ext + CMP_BITS'(5)) begin
          have = 1'b1;
        end
      end
      TYPE_ZIP: begin
        if (cur_await) begin
          // comment length follows the end record, low byte first
          if (p_ext == mpos_ext + CMP_BITS'(20)) begin
            clow_n = data_byte;
          end else if (p_ext == mpos_ext + CMP_BITS'(21)) begin
            have     = 1'b1;
            found    = 1'b1;
            size_ext = mpos_ext + CMP_BITS'(22) + CMP_BITS'({data_byte, cur_clow});
          end
        end else if (p_ext >= CMP_BITS'(7) && window == ZIP_EOCD &&
                     (p_ext - CMP_BITS'(3)) < zl_ext) begin
          await_n = 1'b1;
          mpos_n  = cur_pos - POSITION_BITS'(3);
        end else if (p_ext + CMP_BITS'(1) >= zl_ext + CMP_BITS'(4)) begin
          have = 1'b1;
        end
      end
      default: begin
        have = 1'b1;
      end
    endcase
    // end of stream or position ceiling closes an open search
    if (!have && (stream_end || cur_pos == POS_MAX)) begin
      have = 1'b1;
    end
  end

  // result size with saturation
  always_comb begin
    if (!found) begin
      size_out = type_default(cur_type);
    end else if (size_ext > CMP_BITS'(SIZE_MAX)) begin
      size_out = SIZE_MAX;
    end else begin
      size_out = size_ext[SIZE_BITS-1:0];
    end
  end

  assign active = in_fire && !cur_done;

  // next state
  always_comb begin
    byte_position_next           = byte_position;
    recent_bytes_next            = recent_bytes;
    active_type_next             = active_type;
    search_done_next             = search_done;
    awaiting_comment_length_next = awaiting_comment_length;
    marker_position_next         = marker_position;
    comment_length_low_next      = comment_length_low;
    if (active) begin
      byte_position_next           = (cur_pos < POS_MAX) ? cur_pos + POSITION_BITS'(1) : cur_pos;
      recent_bytes_next            = window;
      active_type_next             = cur_type;
      search_done_next             = have;
      awaiting_comment_length_next = have ? 1'b0 : await_n;
      marker_position_next         = mpos_n;
      comment_length_low_next      = clow_n;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position           <= '0;
      recent_bytes            <= '0;
      active_type             <= '0;
      search_done             <= 1'b1;
      awaiting_comment_length <= 1'b0;
      marker_position         <= '0;
      comment_length_low      <= '0;
    end else begin
      byte_position           <= byte_position_next;
      recent_bytes            <= recent_bytes_next;
      active_type             <= active_type_next;
      search_done             <= search_done_next;
      awaiting_comment_length <= awaiting_comment_length_next;
      marker_position         <= marker_position_next;
      comment_length_low      <= comment_length_low_next;
    end
  end

  assign core_out.push                = active && have;
  assign core_out.result.file_size    = size_out;
  assign core_out.result.marker_found = found;

endmodule

FILE: rtl/ffsf_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsf_result_queue: two-entry result buffer
// Output register plus skid entry so a waiting result does not stall input.
// ----------------------------------------------------------------------------
module ffsf_result_queue import ffsf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  ffsf_core_out_t core_out,
  output logic           has_room,
  output logic           out_valid,
  input  logic           out_ready,
  output ffsf_result_t   out_word
);

  logic [1:0]   count, count_next;
  ffsf_result_t slot0, slot0_next;
  ffsf_result_t slot1, slot1_next;
  logic         push, pop;

  assign push      = core_out.push;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign has_room  = (count != 2'd2);
  assign out_word  = slot0;

  // queue update
  always_comb begin
    count_next = count;
    slot0_next = slot0;
    slot1_next = slot1;
    case (count)
      2'd0: begin
        if (push) begin
          slot0_next = core_out.result;
          count_next = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0_next = core_out.result;
        end else if (push) begin
          slot1_next = core_out.result;
          count_next = 2'd2;
        end else if (pop) begin
          count_next = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_next = slot1;
          count_next = 2'd1;
        end
      end
      default: count_next = 2'd0;
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2))
    else $error("result pushed into full queue");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && pop) |=> (count == 2'd1 && slot0 == $past(slot1)))
    else $error("skid entry not promoted after pop");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> (out_valid && out_word == $past(core_out.result)))
    else $error("pushed result not presented");

endmodule

FILE: rtl/file_footer_size_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_footer_size_finder_top: end-of-file search for carved candidate files
// Scans the bytes of one candidate file and reports its size once.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, with no gaps needed between bytes or between
// files: each byte is matched against the end marker of its file type in the
// cycle it is accepted, and the result word of the byte that settles it is
// registered in a two-entry queue (output register plus skid entry); the byte
// input stalls only while both entries are held by an unread output. A byte
// with first_byte set starts a new search and samples file_type; bytes
// outside an open search are dropped. The user must write limits through the
// configuration port only while no search is in flight, unchecked by the block.
module file_footer_size_finder_top import ffsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ffsf_in_if.sink               in_ch,
  ffsf_out_if.source            out_ch,
  input  logic                  cfg_write_en,
  input  logic [1:0]            cfg_index,
  input  logic [LIMIT_BITS-1:0] cfg_data
);

  ffsf_limits_t   limits;
  ffsf_core_out_t core_out;
  ffsf_result_t   out_word;
  logic           has_room;
  logic           in_fire;

  assign in_ch.ready = has_room;
  assign in_fire     = in_ch.valid && has_room;

  // limit registers
  ffsf_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .limits       (limits)
  );

  // byte matching
  ffsf_search_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .data_byte  (in_ch.data_byte),
    .first_byte (in_ch.first_byte),
    .file_type  (in_ch.file_type),
    .stream_end (in_ch.stream_end),
    .limits     (limits),
    .core_out   (core_out)
  );

  // result buffering
  ffsf_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .core_out  (core_out),
    .has_room  (has_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.file_size    = out_word.file_size;
  assign out_ch.marker_found = out_word.marker_found;

endmodule

FILE: bench/tb_file_footer_size_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_file_footer_size_finder_top: self-checking bench for the footer finder
// A short table of hand-picked bytes, then random candidate files with end
// markers planted, broken or left out, under several search limits and flow
// patterns. Results are checked against typed sizes or the in-bench search model.
// ----------------------------------------------------------------------------
module tb_file_footer_size_finder_top;
  import ffsf_pkg::*;

  localparam int                    CYCLE_LIMIT   = 200000;
  localparam int                    SETTLE_CYCLES = 8;
  localparam int                    PRESS_CYCLES  = 300;
  localparam logic [LIMIT_BITS-1:0] LIMIT_TOP     = LIMIT_BITS'(209715200);
  localparam logic [2:0]            TYPE_SPARE_LO = 3'd5;
  localparam logic [2:0]            TYPE_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SNK_STALL,
    FLOW_BOTH
  } flow_t;

  // how a table row is checked: by the model, nothing expected, or typed value
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_SIZE
  } row_chk_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic [2:0] ftype;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]           data;
    logic                 first;
    logic [2:0]           ftype;
    logic                 last;
    row_chk_t             chk;
    logic [SIZE_BITS-1:0] size;
    logic                 found;
  } table_row_t;

  localparam int N_ROWS = 19;

  // hand-picked bytes: idle drop, other and spare types, png header check,
  // early and valid jpeg end marker, stream end on open searches
  localparam table_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{8'h5A, 1'b0, TYPE_JPEG,     1'b0, CHK_NONE,  '0,         1'b0},
    '{8'hFF, 1'b1, TYPE_OTHER,    1'b0, CHK_SIZE,  DEF_OTHER,  1'b0},
    '{8'h00, 1'b1, TYPE_SPARE_HI, 1'b0, CHK_SIZE,  DEF_OTHER,  1'b0},
    '{8'h00, 1'b1, TYPE_SPARE_LO, 1'b0, CHK_SIZE,  DEF_OTHER,  1'b0},
    '{8'h89, 1'b1, TYPE_PNG,      1'b0, CHK_NONE,  '0,         1'b0},
    '{8'h51, 1'b0, TYPE_PNG,      1'b0, CHK_SIZE,  DEF_PNG,    1'b0},
    '{8'hFF, 1'b1, TYPE_JPEG,     1'b0, CHK_NONE,  '0,         1'b0},
    '{8'hD8, 1'b0, TYPE_JPEG,     1'b0, CHK_NONE,  '0,         1'b0},
    '{8'hFF, 1'b0, TYPE_JPEG,     1'b0, CHK_NONE,  '0,         1'b0},
    '{8'hD9, 1'b0, TYPE_JPEG,     1'b0, CHK_SIZE,  28'd4,      1'b1},
    '{8'hAA, 1'b0, TYPE_JPEG,     1'b1, CHK_NONE,  '0,         1'b0},
    '{8'hFF, 1'b1, TYPE_JPEG,     1'b0, CHK_NONE,  '0,         1'b0},
    '{8'hD9, 1'b0, TYPE_JPEG,     1'b0, CHK_MODEL, '0,         1'b0},
    '{8'h00, 1'b0, TYPE_JPEG,     1'b1, CHK_SIZE,  DEF_JPEG,   1'b0},
    '{8'h25, 1'b1, TYPE_PDF,      1'b1, CHK_SIZE,  DEF_PDF,    1'b0},
    '{8'h50, 1'b1, TYPE_ZIP,      1'b1, CHK_SIZE,  DEF_ZIP,    1'b0},
    '{8'h89, 1'b1, TYPE_PNG,      1'b0, CHK_NONE,  '0,         1'b0},
    '{8'h50, 1'b0, TYPE_PNG,      1'b0, CHK_NONE,  '0,         1'b0},
    '{8'hFF, 1'b0, TYPE_PNG,      1'b1, CHK_SIZE,  DEF_PNG,    1'b0}
  };

  logic clk;
  logic rst;
  logic                  cfg_write_en;
  logic [1:0]            cfg_index;
  logic [LIMIT_BITS-1:0] cfg_data;

  ffsf_in_if  in_ch ();
  ffsf_out_if out_ch ();

  file_footer_size_finder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // search model state
  logic [LIMIT_BITS-1:0]    lim_jpeg, lim_png, lim_pdf, lim_zip;
  logic [POSITION_BITS-1:0] scan_pos;
  logic [31:0]              window;
  logic [2:0]               scan_type;
  logic                     scan_closed;
  logic                     await_len;
  logic [POSITION_BITS-1:0] eocd_pos;
  logic [7:0]               len_low;

  ffsf_result_t pending_sizes [$];
  byte_item_t   byte_plan [$];
  flow_t        flow;
  int           hold_left;
  int           error_count;
  int           cycle_count;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one byte through the search model; returns 1 when it settles a size
  function automatic bit footer_search(input byte_item_t it, output ffsf_result_t res);
    longint unsigned p;
    longint unsigned size;
    logic [31:0]     prev;
    bit              hit;
    bit              found;
    hit   = 1'b0;
    found = 1'b0;
    size  = 0;
    res   = '0;
    if (it.first) begin
      scan_pos    = '0;
      window      = '0;
      scan_type   = it.ftype;
      scan_closed = 1'b0;
      await_len   = 1'b0;
      eocd_pos    = '0;
      len_low     = '0;
    end
    if (scan_closed) return 1'b0;
    p      = scan_pos;
    prev   = window;
    window = {prev[23:0], it.data};
    case (scan_type)
      TYPE_JPEG: begin
        if (p >= 3 && prev[7:0] == JPEG_EOI_LEAD && it.data == JPEG_EOI_TAIL &&
            p - 1 < lim_jpeg) begin
          hit = 1'b1; found = 1'b1; size = p + 1;
        end else if (p + 1 >= lim_jpeg + 2) begin
          hit = 1'b1;
        end
      end
      TYPE_PNG: begin
        if (p == 1 && window[15:0] != PNG_SIG_HEAD) begin
          hit = 1'b1;
        end else if (p >= 11 && window == PNG_IEND && p - 3 < lim_png) begin
          hit = 1'b1; found = 1'b1; size = p + 5;
        end else if (p + 1 >= lim_png + 4) begin
          hit = 1'b1;
        end
      end
      TYPE_PDF: begin
        if (p >= 9 && prev == PDF_EOF_HEAD && it.data == PDF_EOF_TAIL &&
            p - 4 < lim_pdf) begin
          hit = 1'b1; found = 1'b1; size = p + 1;
        end else if (p + 1 >= lim_pdf + 5) begin
          hit = 1'b1;
        end
      end
      TYPE_ZIP: begin
        // after the end record, wait for the two comment length bytes
        if (await_len) begin
          if (p == eocd_pos + 20) begin
            len_low = it.data;
          end else if (p == eocd_pos + 21) begin
            hit = 1'b1; found = 1'b1;
            size = eocd_pos + 22 + {it.data, len_low};
          end
        end else if (p >= 7 && window == ZIP_EOCD && p - 3 < lim_zip) begin
          await_len = 1'b1;
          eocd_pos  = p - 3;
        end else if (p + 1 >= lim_zip + 4) begin
          hit = 1'b1;
        end
      end
      default: hit = 1'b1;
    endcase
    if (!hit && (it.last || p >= POS_MAX)) hit = 1'b1;
    if (scan_pos < POS_MAX) scan_pos++;
    if (!hit) return 1'b0;
    if (!found) begin
      case (scan_type)
        TYPE_JPEG: size = DEF_JPEG;
        TYPE_PNG:  size = DEF_PNG;
        TYPE_PDF:  size = DEF_PDF;
        TYPE_ZIP:  size = DEF_ZIP;
        default:   size = DEF_OTHER;
      endcase
    end
    if (size > SIZE_MAX) size = SIZE_MAX;
    scan_closed      = 1'b1;
    await_len        = 1'b0;
    res.file_size    = size[SIZE_BITS-1:0];
    res.marker_found = found;
    return 1'b1;
  endfunction

  function automatic bit src_pause();
    case (flow)
      FLOW_SRC_IDLE: return $urandom_range(0, 99) < 80;
      FLOW_BOTH:     return $urandom_range(0, 99) < 9;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit snk_pause();
    case (flow)
      FLOW_SNK_STALL: return $urandom_range(0, 99) < 80;
      FLOW_BOTH:      return $urandom_range(0, 99) < 9;
      default:        return 1'b0;
    endcase
  endfunction

  // random byte, leaning on marker bytes to provoke near misses
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       return JPEG_EOI_LEAD;
      1:       return JPEG_EOI_TAIL;
      2:       return PNG_IEND[31:24];
      3:       return PNG_IEND[23:16];
      4:       return PNG_IEND[7:0];
      5:       return PDF_EOF_HEAD[31:24];
      6:       return PDF_EOF_TAIL;
      7:       return ZIP_EOCD[31:24];
      8:       return ZIP_EOCD[23:16];
      default: return ZIP_EOCD[7:0];
    endcase
  endfunction

  // receiver: long hold when asked, else stall by flow pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = !snk_pause();
    end
  end

  // result check against the oldest expected size
  always @(posedge clk) begin : result_check
    ffsf_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_sizes.size() == 0) begin
        $error("unexpected result: file_size %0d marker_found %0d",
               out_ch.file_size, out_ch.marker_found);
        error_count++;
      end else begin
        want = pending_sizes.pop_front();
        if (out_ch.file_size !== want.file_size) begin
          $error("file_size: expected %0d, got %0d", want.file_size, out_ch.file_size);
          error_count++;
        end
        if (out_ch.marker_found !== want.marker_found) begin
          $error("marker_found: expected %0d, got %0d", want.marker_found,
                 out_ch.marker_found);
          error_count++;
        end
      end
    end
  end

  // offer one word, wait for acceptance, then record what it should yield
  task automatic send_byte(input byte_item_t it, input row_chk_t chk,
                           input ffsf_result_t typed);
    ffsf_result_t res;
    bit           hit;
    @(negedge clk);
    while (src_pause()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.data_byte  = it.data;
    in_ch.first_byte = it.first;
    in_ch.file_type  = it.ftype;
    in_ch.stream_end = it.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    hit = footer_search(it, res);
    case (chk)
      CHK_MODEL: if (hit) pending_sizes.push_back(res);
      CHK_SIZE:  pending_sizes.push_back(typed);
      default:   ;
    endcase
  endtask

  task automatic write_limit(input ffsf_reg_t idx, input logic [LIMIT_BITS-1:0] value);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = value;
    case (idx)
      REG_JPEG_LIMIT: lim_jpeg = value;
      REG_PNG_LIMIT:  lim_png  = value;
      REG_PDF_LIMIT:  lim_pdf  = value;
      default:        lim_zip  = value;
    endcase
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // wait for every expected size, then let the pipeline run dry
  task automatic settle();
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one candidate file: marker planted, broken or absent, plus some noise
  task automatic plan_file();
    logic [7:0] mk [$];
    logic [7:0] body [];
    logic [2:0] ft;
    byte_item_t it;
    int         roll, style, mpos, tail, len, k;
    roll = $urandom_range(0, 99);
    if (roll < 22)      ft = TYPE_JPEG;
    else if (roll < 44) ft = TYPE_PNG;
    else if (roll < 64) ft = TYPE_PDF;
    else if (roll < 86) ft = TYPE_ZIP;
    else if (roll < 94) ft = TYPE_OTHER;
    else                ft = 3'($urandom_range(TYPE_SPARE_LO, TYPE_SPARE_HI));
    case (ft)
      TYPE_JPEG: begin
        mk.push_back(JPEG_EOI_LEAD); mk.push_back(JPEG_EOI_TAIL);
      end
      TYPE_PNG: begin
        for (k = 3; k >= 0; k--) mk.push_back(PNG_IEND[k*8 +: 8]);
      end
      TYPE_PDF: begin
        for (k = 3; k >= 0; k--) mk.push_back(PDF_EOF_HEAD[k*8 +: 8]);
        mk.push_back(PDF_EOF_TAIL);
      end
      TYPE_ZIP: begin
        for (k = 3; k >= 0; k--) mk.push_back(ZIP_EOCD[k*8 +: 8]);
      end
      default: ;
    endcase
    style = $urandom_range(0, 99);
    mpos  = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 12) : $urandom_range(0, 48);
    if (ft == TYPE_ZIP)
      tail = ($urandom_range(0, 99) < 85) ? 18 + $urandom_range(0, 4) : $urandom_range(0, 18);
    else
      tail = $urandom_range(0, 6);
    len  = (mk.size() == 0) ? $urandom_range(1, 12) : mpos + mk.size() + tail;
    body = new[len];
    foreach (body[i]) body[i] = pick_byte();
    if (ft == TYPE_PNG && $urandom_range(0, 9) != 0) begin
      body[0] = PNG_SIG_HEAD[15:8];
      body[1] = PNG_SIG_HEAD[7:0];
    end
    // plant the marker when well formed or broken
    if (mk.size() != 0 && style < 87) begin
      foreach (mk[i]) body[mpos + i] = mk[i];
      if (style >= 75) begin
        k = $urandom_range(0, mk.size() - 1);
        body[mpos + k] = body[mpos + k] ^ 8'($urandom_range(1, 255));
      end
      if (ft == TYPE_ZIP && len >= mpos + 22) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          body[mpos + 20] = 8'hFF; body[mpos + 21] = 8'hFF;
        end else if (roll == 1) begin
          body[mpos + 20] = 8'h00; body[mpos + 21] = 8'h00;
        end
      end
    end
    foreach (body[i]) begin
      it.data  = body[i];
      it.first = (i == 0);
      it.ftype = (i == 0) ? ft : 3'($urandom_range(0, 7));
      it.last  = (i == len - 1) ? ($urandom_range(0, 1) == 1) : 1'b0;
      byte_plan.push_back(it);
    end
    // stray words between files
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) begin
        it.data  = 8'($urandom_range(0, 255));
        it.first = ($urandom_range(0, 7) == 0);
        it.ftype = 3'($urandom_range(0, 7));
        it.last  = ($urandom_range(0, 1) == 1);
        byte_plan.push_back(it);
      end
    end
  endtask

  // random files, closed by a stream end so the block ends up idle
  task automatic random_run(input int n_items);
    byte_item_t it;
    byte_plan.delete();
    while (byte_plan.size() < n_items) plan_file();
    it.data  = 8'($urandom_range(0, 255));
    it.first = 1'b0;
    it.ftype = 3'($urandom_range(0, 7));
    it.last  = 1'b1;
    byte_plan.push_back(it);
    foreach (byte_plan[i]) send_byte(byte_plan[i], CHK_MODEL, '0);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_BITS-1:0] lj, lp, lf, lz,
                           input flow_t mode, input bit press, input int n_items);
    settle();
    write_limit(REG_JPEG_LIMIT, lj);
    write_limit(REG_PNG_LIMIT, lp);
    write_limit(REG_PDF_LIMIT, lf);
    write_limit(REG_ZIP_LIMIT, lz);
    flow = mode;
    if (press) hold_left = PRESS_CYCLES;
    random_run(n_items);
  endtask

  function automatic logic [LIMIT_BITS-1:0] small_limit();
    return LIMIT_BITS'($urandom_range(0, 48));
  endfunction

  // main sequence
  initial begin
    ffsf_result_t typed;
    byte_item_t   it;
    rst              = 1'b1;
    cfg_write_en     = 1'b0;
    cfg_index        = REG_JPEG_LIMIT;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.file_type  = TYPE_JPEG;
    in_ch.stream_end = 1'b0;
    out_ch.ready     = 1'b0;
    flow             = FLOW_FREE;
    hold_left        = 0;
    error_count      = 0;
    cycle_count      = 0;
    lim_jpeg    = RST_JPEG_LIMIT;
    lim_png     = RST_PNG_LIMIT;
    lim_pdf     = RST_PDF_LIMIT;
    lim_zip     = RST_ZIP_LIMIT;
    scan_pos    = '0;
    window      = '0;
    scan_type   = TYPE_JPEG;
    scan_closed = 1'b1;
    await_len   = 1'b0;
    eocd_pos    = '0;
    len_low     = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table under reset limits
    foreach (DIRECTED_ROWS[r]) begin
      it.data            = DIRECTED_ROWS[r].data;
      it.first           = DIRECTED_ROWS[r].first;
      it.ftype           = DIRECTED_ROWS[r].ftype;
      it.last            = DIRECTED_ROWS[r].last;
      typed.file_size    = DIRECTED_ROWS[r].size;
      typed.marker_found = DIRECTED_ROWS[r].found;
      send_byte(it, DIRECTED_ROWS[r].chk, typed);
    end
    random_run(150);

    // limit settings: extremes, marker-start boundaries, small random ones
    run_phase(LIMIT_TOP, LIMIT_TOP, LIMIT_TOP, LIMIT_TOP, FLOW_SRC_IDLE, 1'b0, 200);
    run_phase('0, '0, '0, '0, FLOW_SNK_STALL, 1'b0, 120);
    run_phase(28'd2, 28'd8, 28'd5, 28'd4, FLOW_BOTH, 1'b0, 200);
    run_phase(28'd3, 28'd9, 28'd6, 28'd5, FLOW_FREE, 1'b1, 200);
    run_phase(small_limit(), small_limit(), small_limit(), small_limit(),
              FLOW_SRC_IDLE, 1'b0, 200);
    run_phase(small_limit(), small_limit(), small_limit(), small_limit(),
              FLOW_SNK_STALL, 1'b0, 200);
    run_phase(small_limit(), small_limit(), small_limit(), small_limit(),
              FLOW_BOTH, 1'b0, 200);
    run_phase(RST_JPEG_LIMIT, RST_PNG_LIMIT, RST_PDF_LIMIT, RST_ZIP_LIMIT,
              FLOW_FREE, 1'b0, 200);
    run_phase(28'd1, 28'd1, 28'd1, 28'd1, FLOW_BOTH, 1'b0, 130);

    settle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
